// ----- hdl/iaf_pkg.sv -----
`default_nettype none
package iaf_pkg;

  localparam int IdxW = 2;
  localparam int CfgW = 31;

  localparam logic [IdxW-1:0] REG_BARO_WEIGHT  = 2'd0;
  localparam logic [IdxW-1:0] REG_ACCEL_WEIGHT = 2'd1;
  localparam logic [IdxW-1:0] REG_BIAS_WEIGHT  = 2'd2;
  localparam logic [IdxW-1:0] REG_GRAVITY      = 2'd3;

  localparam logic [CfgW-1:0] BARO_WEIGHT_RST  = 31'd32768;
  localparam logic [CfgW-1:0] ACCEL_WEIGHT_RST = 31'd1310720;
  localparam logic [CfgW-1:0] BIAS_WEIGHT_RST  = 31'd3277;
  localparam logic [CfgW-1:0] GRAVITY_RST      = 31'd642689;

  // Unit operation codes.
  localparam logic [1:0] OP_Q16  = 2'd0;  // a*b, round at 16 bits, saturate
  localparam logic [1:0] OP_Q14  = 2'd1;  // (acc + a*b), round at 14, saturate
  localparam logic [1:0] OP_MAC  = 2'd2;  // acc + a*b, no rounding
  localparam logic [1:0] OP_DIV3 = 2'd3;  // a*b >> 33, for a reciprocal of 3

  // ceil(2^33 / 3): (n * DIV3_MUL) >> 33 equals n / 3 for any n below 2^32.
  localparam logic signed [32:0] DIV3_MUL = 33'sh0AAAAAAAB;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    begin
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/iaf_mul_unit.sv -----
`default_nettype none
// Shared multiplier: one 33x33 signed product a cycle, registered. On the
// next cycle the result of op, saturated, is presented on res; for a started
// op the accumulator takes the running sum or clears at the following edge.
module iaf_mul_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          op,
  input  wire logic signed [32:0]  a,
  input  wire logic signed [32:0]  b,
  output logic signed [31:0]       res
);
  import iaf_pkg::*;

  logic signed [65:0] prod;
  logic [1:0]         op_q;
  logic               go_q;
  logic signed [65:0] acc;
  logic signed [65:0] sum;
  logic signed [65:0] rnd;

  // Product register.
  always_ff @(posedge clk) begin
    prod <= 66'(a) * 66'(b);
    op_q <= op;
    go_q <= start;
  end

  // Rounding step: floor((x + half) >> sh) matches round half up.
  always_comb begin
    sum = (op_q == OP_Q16) ? prod : acc + prod;
    unique case (op_q)
      OP_Q16:  rnd = (sum + 66'sd32768) >>> 16;
      OP_Q14:  rnd = (sum + 66'sd8192) >>> 14;
      OP_DIV3: rnd = prod >>> 33;
      OP_MAC:  rnd = sum;
    endcase
  end

  assign res = sat32(rnd);

  // Accumulator keeps the sum across MAC steps and clears otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 66'sd0;
    end else if (go_q) begin
      if (op_q == OP_MAC) acc <= sum;
      else acc <= 66'sd0;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/inertial_altitude_filter.sv -----
`default_nettype none
// Channel  | Dir | Contents
// s_axis   | in  | tdata: dt_step, baro_altitude, accel_x/y/z, rot_x/y/z_down
//          |     | tuser: sensors_ready, baro_new, accel_new
// m_axis   | out | tdata: altitude_down, velocity_down, accel_down
// cfg      | in  | cfg_we, cfg_index, cfg_data
// A ready tick runs in the sequencer as 24 steps of the shared multiplier
// (the two bias steps run once per axis), each a product phase and then a
// round phase. A tick with sensors not ready goes straight to output.
// The result waits in an output register; s_axis_tready returns once it
// is taken. Reset is synchronous, clears state and loads default gains.
module inertial_altitude_filter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // dt_step[15:0], baro_altitude[47:16], accel_x[79:48], accel_y[111:80],
  // accel_z[143:112], rot_x_down[159:144], rot_y_down[175:160],
  // rot_z_down[191:176]
  input  wire logic [191:0] s_axis_tdata,
  // sensors_ready[0], baro_new[1], accel_new[2]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // altitude_down[31:0], velocity_down[63:32], accel_down[95:64]
  output logic [95:0]       m_axis_tdata,
  input  wire logic                     cfg_we,
  input  wire logic [iaf_pkg::IdxW-1:0] cfg_index,
  input  wire logic [iaf_pkg::CfgW-1:0] cfg_data
);
  import iaf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state;
  logic [5:0] step;
  logic       phase;
  logic [1:0] bias_axis;

  logic [CfgW-1:0] wb, wa, wbias, grav;
  logic signed [31:0] x0, x1, x2, bx, by, bz, berr, aerr;
  // Scratch registers for intermediates.
  logic signed [31:0] ta, tb, tc, td;
  logic [15:0] dt;
  logic signed [15:0] rx, ry, rz;
  logic anew;

  logic [1:0] op;
  logic signed [32:0] ma, mb;
  logic signed [31:0] mres;
  logic start;

  iaf_mul_unit u_mul (
    .clk(clk), .rst(rst), .start(start), .op(op), .a(ma), .b(mb), .res(mres)
  );

  localparam logic [5:0] LAST = 6'd19;

  function automatic logic signed [32:0] s33(input logic signed [31:0] v);
    s33 = 33'(v);
  endfunction
  function automatic logic signed [32:0] u33(input logic [CfgW-1:0] v);
    u33 = {2'b00, v};
  endfunction
  function automatic logic signed [32:0] r33(input logic signed [15:0] v);
    r33 = 33'(v);
  endfunction
  function automatic logic signed [31:0] add2(input logic signed [31:0] p,
                                              input logic signed [31:0] q);
    add2 = sat32(66'(p) + 66'(q));
  endfunction

  // Operand selection for each step.
  always_comb begin
    op = OP_Q16;
    ma = '0;
    mb = '0;
    unique case (step)
      6'd0: begin op = OP_MAC; ma = s33(ta); mb = r33(rx); end
      6'd1: begin op = OP_MAC; ma = s33(tb); mb = r33(ry); end
      6'd2: begin op = OP_Q14; ma = s33(tc); mb = r33(rz); end
      6'd3: begin ma = s33(berr); mb = u33(wb); end
      6'd4: begin ma = s33(ta); mb = u33(wb); end
      6'd5: begin op = OP_Q14; ma = s33(ta); mb = r33(rx); end
      6'd6: begin op = OP_Q14; ma = s33(ta); mb = r33(ry); end
      6'd7: begin op = OP_Q14; ma = s33(ta); mb = r33(rz); end
      6'd8: begin ma = s33(tb); mb = u33(wbias); end
      6'd9: begin ma = s33(tb); mb = {17'd0, dt}; end
      6'd10: begin ma = s33(x2); mb = {17'd0, dt}; end
      6'd11: begin ma = s33(td); mb = {17'd0, dt}; end
      6'd12: begin ma = s33(x1); mb = {17'd0, dt}; end
      6'd13: begin ma = s33(berr); mb = u33(wb); end
      6'd14: begin ma = s33(tc); mb = {17'd0, dt}; end
      6'd15: begin ma = s33(tc); mb = u33(wb); end
      6'd16: begin ma = s33(tb); mb = u33(wb); end
      // Divide by three on the magnitude; the sign is put back on use.
      6'd17: begin
        op = OP_DIV3;
        ma = tb[31] ? -s33(tb) : s33(tb);
        mb = DIV3_MUL;
      end
      6'd18: begin ma = s33(aerr); mb = u33(wa); end
      6'd19: begin ma = s33(tb); mb = {17'd0, dt}; end
      default: ;
    endcase
  end

  assign start = (state == ST_RUN) && !phase;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {x2, x1, x0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      phase <= 1'b0;
      bias_axis <= '0;
      wb <= BARO_WEIGHT_RST; wa <= ACCEL_WEIGHT_RST;
      wbias <= BIAS_WEIGHT_RST; grav <= GRAVITY_RST;
      x0 <= '0; x1 <= '0; x2 <= '0;
      bx <= '0; by <= '0; bz <= '0;
      berr <= '0; aerr <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BARO_WEIGHT:  wb <= cfg_data;
          REG_ACCEL_WEIGHT: wa <= cfg_data;
          REG_BIAS_WEIGHT:  wbias <= cfg_data;
          REG_GRAVITY:      grav <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dt <= s_axis_tdata[15:0];
            rx <= s_axis_tdata[159:144];
            ry <= s_axis_tdata[175:160];
            rz <= s_axis_tdata[191:176];
            anew <= s_axis_tuser[2];
            // Bias-corrected accelerations and fresh barometer error.
            ta <= sat32(66'($signed(s_axis_tdata[79:48])) - 66'(bx));
            tb <= sat32(66'($signed(s_axis_tdata[111:80])) - 66'(by));
            tc <= sat32(66'($signed(s_axis_tdata[143:112])) - 66'(bz));
            if (s_axis_tuser[0] && s_axis_tuser[1])
              berr <= sat32(-66'($signed(s_axis_tdata[47:16])) - 66'(x0));
            step <= '0;
            phase <= 1'b0;
            bias_axis <= '0;
            state <= s_axis_tuser[0] ? ST_RUN : ST_OUT;
          end
        end
        ST_RUN: begin
          phase <= !phase;
          if (phase) begin
            // The bias steps repeat once for each of the three axes.
            if (step == 6'd9 && bias_axis != 2'd2) step <= 6'd8;
            else step <= step + 6'd1;
            if (step == 6'd9) bias_axis <= bias_axis + 2'd1;
            if (step == LAST) state <= ST_OUT;
            // Consume the rounded result of the step just finished.
            unique case (step)
              6'd2: if (anew)
                aerr <= sat32(66'(sat32(-66'(mres))) + 66'(grav) - 66'(x2));
              6'd3: ta <= mres;
              6'd4: ta <= sat32(-66'(mres));
              6'd5: tb <= mres;
              6'd6: tc <= mres;
              6'd7: td <= mres;
              6'd8: tb <= mres;
              6'd9: begin
                if (bias_axis == 2'd0) begin
                  bx <= add2(bx, mres);
                  tb <= tc;
                end else if (bias_axis == 2'd1) begin
                  by <= add2(by, mres);
                  tb <= td;
                end else begin
                  bz <= sat32(66'(bz) - 66'(mres));
                end
              end
              6'd10: td <= mres;  // x2*dt
              6'd11: tc <= mres;  // t
              6'd12: begin
                x0 <= sat32(66'(x0) + 66'(mres) + 66'(tc / 2));
                x1 <= add2(x1, td);
              end
              6'd13: tc <= mres;
              6'd14: begin tc <= mres; x0 <= add2(x0, mres); end
              6'd15: begin x1 <= add2(x1, mres); tb <= mres; end
              6'd16: tb <= mres;
              6'd17: x2 <= sat32(66'(x2) + (tb[31] ? -66'(mres) : 66'(mres)));
              6'd18: tb <= mres;
              6'd19: x2 <= add2(x2, mres);
              default: ;
            endcase
          end
        end
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/inertial_altitude_filter_tb.sv -----
`timescale 1ns / 1ps
module inertial_altitude_filter_tb;
  import iaf_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic            cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  inertial_altitude_filter uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] accel_down;
    logic [31:0] velocity_down;
    logic [31:0] altitude_down;
  } estimate_t;

  // Filter state mirrored in the testbench.
  logic signed [31:0] est_alt, est_vel, est_acc;
  logic signed [31:0] bias_acc [3];
  logic signed [31:0] baro_err, acc_err;
  logic [30:0] w_baro, w_accel, w_bias, g_down;

  estimate_t expected_estimates[$];
  int errors = 0;
  int ticks_sent = 0;
  int estimates_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycle_count = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Round half up at sh bits: floor((p + half) / 2^sh).
  function automatic logic signed [95:0] round_at(input logic signed [95:0] p,
                                                  input int sh);
    logic signed [95:0] q;
    q = p + (96'sd1 <<< (sh - 1));
    return q >>> sh;
  endfunction

  function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
                                               input logic signed [47:0] b);
    logic signed [95:0] p;
    p = 96'(a) * 96'(b);
    return clamp32(round_at(p, 16));
  endfunction

  // Division that truncates toward zero.
  function automatic logic signed [95:0] tdiv(input logic signed [31:0] a,
                                              input int d);
    logic signed [95:0] m;
    m = (a < 0) ? -96'(a) : 96'(a);
    m = m / d;
    return (a < 0) ? -m : m;
  endfunction

  task automatic predict_tick(input logic [191:0] data, input logic [2:0] flags);
    logic signed [47:0] dt, wb, wa, wbias;
    logic signed [31:0] acc [3];
    logic signed [15:0] rot [3];
    logic signed [95:0] sum;
    logic signed [31:0] a, down, corr, c, inc, t, x0, x1, x2, ewdt;
    estimate_t e;
    dt = 48'(data[15:0]);
    wb = 48'(w_baro);
    wa = 48'(w_accel);
    wbias = 48'(w_bias);
    for (int k = 0; k < 3; k++) begin
      acc[k] = data[48 + 32*k +: 32];
      rot[k] = data[144 + 16*k +: 16];
    end
    if (flags[0]) begin
      if (flags[1])
        baro_err = clamp32(-96'(signed'(data[47:16])) - 96'(est_alt));
      if (flags[2]) begin
        sum = '0;
        for (int k = 0; k < 3; k++) begin
          a = clamp32(96'(acc[k]) - 96'(bias_acc[k]));
          sum += 96'(a) * 96'(rot[k]);
        end
        down = clamp32(-96'(clamp32(round_at(sum, 14))));
        acc_err = clamp32(96'(down) + 96'(signed'({1'b0, g_down})) - 96'(est_acc));
      end
      // Bias learning driven by the barometer error.
      corr = clamp32(-96'(fxmul(fxmul(baro_err, wb), wb)));
      for (int k = 0; k < 3; k++) begin
        c = clamp32(round_at(96'(corr) * 96'(rot[k]), 14));
        inc = fxmul(fxmul(c, wbias), dt);
        if (k < 2) bias_acc[k] = clamp32(96'(bias_acc[k]) + 96'(inc));
        else bias_acc[k] = clamp32(96'(bias_acc[k]) - 96'(inc));
      end
      // Kinematic prediction, then the two corrections.
      x0 = est_alt; x1 = est_vel; x2 = est_acc;
      t = fxmul(fxmul(x2, dt), dt);
      x0 = clamp32(96'(x0) + 96'(fxmul(x1, dt)) + tdiv(t, 2));
      x1 = clamp32(96'(x1) + 96'(fxmul(x2, dt)));
      ewdt = fxmul(fxmul(baro_err, wb), dt);
      x0 = clamp32(96'(x0) + 96'(ewdt));
      x1 = clamp32(96'(x1) + 96'(fxmul(ewdt, wb)));
      x2 = clamp32(96'(x2) + tdiv(fxmul(fxmul(ewdt, wb), wb), 3));
      ewdt = fxmul(fxmul(acc_err, wa), dt);
      x2 = clamp32(96'(x2) + 96'(ewdt));
      est_alt = x0; est_vel = x1; est_acc = x2;
    end
    e.altitude_down = est_alt;
    e.velocity_down = est_vel;
    e.accel_down = est_acc;
    expected_estimates.push_back(e);
  endtask

  // Send one tick request, predicting it when accepted.
  task automatic send_tick(input logic [191:0] data, input logic [2:0] flags);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= flags;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_tick(data, flags);
    ticks_sent++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [191:0] pack_tick(input logic [15:0] dt,
      input logic [31:0] balt, input logic [31:0] ax, input logic [31:0] ay,
      input logic [31:0] az, input logic [15:0] rx, input logic [15:0] ry,
      input logic [15:0] rz);
    return {rz, ry, rx, az, ay, ax, balt, dt};
  endfunction

  function automatic logic [15:0] rand_rot();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_wide();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic wait_drain();
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BARO_WEIGHT:  w_baro = val;
      REG_ACCEL_WEIGHT: w_accel = val;
      REG_BIAS_WEIGHT:  w_bias = val;
      default:          g_down = val;
    endcase
    @(posedge clk);
  endtask

  // Receiver side: random stalls and the scoreboard.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        estimate_t got, exp_e;
        got = m_axis_tdata;
        estimates_seen++;
        if (expected_estimates.size() == 0) begin
          $error("unexpected estimate %h", m_axis_tdata);
          errors++;
        end else begin
          exp_e = expected_estimates.pop_front();
          if (got.altitude_down !== exp_e.altitude_down) begin
            $error("altitude_down expected %h got %h", exp_e.altitude_down,
                   got.altitude_down);
            errors++;
          end
          if (got.velocity_down !== exp_e.velocity_down) begin
            $error("velocity_down expected %h got %h", exp_e.velocity_down,
                   got.velocity_down);
            errors++;
          end
          if (got.accel_down !== exp_e.accel_down) begin
            $error("accel_down expected %h got %h", exp_e.accel_down,
                   got.accel_down);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    // Extremes of every field, not-ready ticks, and all flag mixes but 3'b100.
    send_tick(pack_tick(16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0), 3'b000);
    send_tick(pack_tick(16'd0, 32'h00010000, 32'd0, 32'd0, 32'h000a0000,
                        16'd0, 16'd0, 16'sd16384), 3'b111);
    send_tick(pack_tick(16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 16'sd16384, 16'sd16384, 16'sd16384), 3'b111);
    send_tick(pack_tick(16'hffff, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, -16'sd16384, -16'sd16384, -16'sd16384), 3'b111);
    send_tick(pack_tick(16'hffff, 32'hffffffff, 32'hffffffff, 32'd1, 32'd0,
                        16'd1, -16'sd1, 16'd0), 3'b110);
    send_tick(pack_tick(16'd1, 32'h12345678, 32'd5, 32'd6, 32'd7,
                        16'd100, 16'd200, 16'd300), 3'b011);
    send_tick(pack_tick(16'd655, 32'd0, 32'h00100000, 32'd0, 32'hfff60000,
                        16'd0, 16'd0, 16'sd16384), 3'b101);
    send_tick(pack_tick(16'd1311, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0,
                        16'd0), 3'b001);
    send_tick(pack_tick(16'hffff, 32'h7fffffff, 32'd0, 32'd0, 32'd0,
                        16'd0, 16'd0, 16'd0), 3'b010);
    for (int i = 0; i < 8; i++)
      send_tick(pack_tick(16'hffff, rand_wide(), rand_wide(), rand_wide(),
                          rand_wide(), rand_rot(), rand_rot(), rand_rot()), 3'b111);
  endtask

  task automatic test_random(input int count);
    logic [2:0] flags;
    for (int i = 0; i < count; i++) begin
      flags = 3'($urandom);
      if ($urandom_range(9) < 8) flags[0] = 1'b1;
      send_tick(pack_tick(($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1311)),
                          rand_wide(), rand_wide(), rand_wide(), rand_wide(),
                          rand_rot(), rand_rot(), rand_rot()), flags);
    end
  endtask

  task automatic test_settings();
    logic [CfgW-1:0] vals [4];
    for (int pass = 0; pass < 4; pass++) begin
      wait_drain();
      case (pass)
        0: vals = '{31'd0, 31'd0, 31'd0, 31'd0};
        1: vals = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
        default: vals = '{31'($urandom_range(131072)), 31'($urandom_range(2000000)),
                          31'($urandom_range(20000)), 31'($urandom_range(700000))};
      endcase
      write_reg(REG_BARO_WEIGHT, vals[0]);
      write_reg(REG_ACCEL_WEIGHT, vals[1]);
      write_reg(REG_BIAS_WEIGHT, vals[2]);
      write_reg(REG_GRAVITY, vals[3]);
      test_random(60);
    end
    wait_drain();
    write_reg(REG_BARO_WEIGHT, BARO_WEIGHT_RST);
    write_reg(REG_ACCEL_WEIGHT, ACCEL_WEIGHT_RST);
    write_reg(REG_BIAS_WEIGHT, BIAS_WEIGHT_RST);
    write_reg(REG_GRAVITY, GRAVITY_RST);
  endtask

  initial begin
    est_alt = '0; est_vel = '0; est_acc = '0;
    bias_acc = '{default: '0};
    baro_err = '0; acc_err = '0;
    w_baro = BARO_WEIGHT_RST; w_accel = ACCEL_WEIGHT_RST;
    w_bias = BIAS_WEIGHT_RST; g_down = GRAVITY_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 19; recv_idle_pct = 52;
    test_directed();
    test_random(350);
    // Hold off until the pipeline is empty before continuing.
    wait_drain();
    send_idle_pct = 52; recv_idle_pct = 19;
    test_settings();
    test_random(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(380);
    wait_drain();
    $display("Ran %0d filter ticks (%0d estimates checked) across gain settings,",
             ticks_sent, estimates_seen);
    $display("sensor flag mixes and field extremes, with varied back-pressure.");
    if (errors == 0 && expected_estimates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
